// ----- design/ffca_pkg.sv -----
// Shared types and codes of the first-fit cell allocator.
`default_nettype none
package ffca_pkg;

  localparam int unsigned DefMemCells = 128;
  localparam int unsigned HandleW     = 16;
  localparam logic [16:0] HandleLimit = 17'd65535;
  localparam logic [7:0]  CfgReset    = 8'd128;

  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_ERASE  = 2'd1,
    KIND_DEFRAG = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_NULL      = 2'd1,
    ST_ILLEGAL   = 2'd2
  } status_e;

  // What every cell of the row does in the current cycle.
  typedef enum logic [1:0] {
    CM_HOLD    = 2'd0,
    CM_SHIFT   = 2'd1,
    CM_COMPACT = 2'd2
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e         mode;
    logic               phase;
    logic [HandleW-1:0] tail;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- design/first_fit_cell_allocator.sv -----
// Top level of the first-fit cell allocator: register, sequencer and cell row.
//
// Requests arrive on a valid/ready channel (kind, request_length, erase_handle)
// and results leave on a valid/ready channel (status, handle). One request is
// worked at a time; in_ready_o is high only while the block is idle.
// The cells form a chain that shifts toward cell 0 and refills at the top of
// the managed range, so the sequencer sees one cell per cycle at cell 0.
// With m managed cells: an alloc makes a scan rotation and, if a free run is
// found, a fill rotation; an erase makes one rotation and a defragment runs
// odd-even compaction over the row; rejected requests skip the row. A result
// passes through S_FINISH into the output register before the block is idle.
// The result register frees the chain: a pending result waits there while the
// next request is taken; a second result waits in the sequencer until the
// receiver takes the first, and no request is accepted meanwhile.
// Reset clears every cell to free, sets the next handle to 1 and the managed
// cell count register to 128. The count is written by cfg_we_i/cfg_wdata_i;
// the user must do so only while the block is idle, as the block does not
// enforce it; values above MEM_CELLS act as MEM_CELLS.
`default_nettype none
module first_fit_cell_allocator #(
  parameter int unsigned MEM_CELLS = ffca_pkg::DefMemCells
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire  [7:0]                    cfg_wdata_i,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire  [1:0]                    kind_i,
  input  wire  [7:0]                    request_length_i,
  input  wire  [ffca_pkg::HandleW-1:0]  erase_handle_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic [1:0]                    status_o,
  output logic [ffca_pkg::HandleW-1:0]  handle_o
);
  import ffca_pkg::*;

  localparam int unsigned AW = $clog2(MEM_CELLS + 1);

  logic [7:0]         cfg_q;
  logic [AW-1:0]      m;
  cell_ctrl_t         ctrl;
  logic [HandleW-1:0] owner [MEM_CELLS];

  // Managed cell count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Saturate the count to the built depth.
  always_comb begin
    if (int'(cfg_q) > int'(MEM_CELLS)) m = AW'(MEM_CELLS);
    else m = AW'(int'(cfg_q));
  end

  ffca_ctrl #(.AW(AW)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i, .request_length_i,
    .erase_handle_i, .out_valid_o, .out_ready_i, .status_o, .handle_o,
    .m_i(m), .head_i(owner[0]), .ctrl_o(ctrl)
  );

  // The row of cells, each wired to its two neighbors.
  for (genvar g = 0; g < MEM_CELLS; g++) begin : g_cell
    logic [HandleW-1:0] lft, rgt;
    if (g == 0) begin : g_lo
      assign lft = '0;
    end else begin : g_lm
      assign lft = owner[g-1];
    end
    if (g == MEM_CELLS - 1) begin : g_hi
      assign rgt = '0;
    end else begin : g_hm
      assign rgt = owner[g+1];
    end
    ffca_cell #(.IDX(g), .AW(AW)) u_cell (
      .clk_i, .rst_ni, .ctrl_i(ctrl), .m_i(m),
      .left_i(lft), .right_i(rgt), .owner_o(owner[g])
    );
  end

endmodule
`default_nettype wire

// ----- design/ffca_cell.sv -----
// One cell of the row: holds an owner handle and trades it with its neighbors.
`default_nettype none
module ffca_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned AW  = 8
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  ffca_pkg::cell_ctrl_t              ctrl_i,
  input  wire  [AW-1:0]                     m_i,
  input  wire  [ffca_pkg::HandleW-1:0]      left_i,
  input  wire  [ffca_pkg::HandleW-1:0]      right_i,
  output logic [ffca_pkg::HandleW-1:0]      owner_o
);
  import ffca_pkg::*;

  localparam logic Par = 1'(IDX % 2);
  localparam logic ParL = 1'((IDX + 1) % 2);

  logic [HandleW-1:0] owner_d, owner_q;

  // Next owner: shift toward cell 0, odd-even compaction step, or hold.
  always_comb begin
    owner_d = owner_q;
    case (ctrl_i.mode)
      CM_SHIFT: begin
        if (IDX + 1 < int'(m_i)) begin
          owner_d = right_i;
        end else if (IDX + 1 == int'(m_i)) begin
          owner_d = ctrl_i.tail;
        end
      end
      CM_COMPACT: begin
        if (ctrl_i.phase == Par && IDX + 1 < int'(m_i)) begin
          if (owner_q == '0 && right_i != '0) owner_d = right_i;
        end else if (IDX >= 1 && ctrl_i.phase == ParL && IDX < int'(m_i)) begin
          if (left_i == '0 && owner_q != '0) owner_d = '0;
        end
      end
      default: owner_d = owner_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q <= '0;
    end else begin
      owner_q <= owner_d;
    end
  end

  assign owner_o = owner_q;

endmodule
`default_nettype wire

// ----- design/ffca_ctrl.sv -----
// Sequencer that steps the cell row through scan, fill, erase and compaction.
`default_nettype none
module ffca_ctrl #(
  parameter int unsigned AW = 8
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire  [1:0]                    kind_i,
  input  wire  [7:0]                    request_length_i,
  input  wire  [ffca_pkg::HandleW-1:0]  erase_handle_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic [1:0]                    status_o,
  output logic [ffca_pkg::HandleW-1:0]  handle_o,
  input  wire  [AW-1:0]                 m_i,
  input  wire  [ffca_pkg::HandleW-1:0]  head_i,
  output ffca_pkg::cell_ctrl_t          ctrl_o
);
  import ffca_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_FILL    = 6'b000100,
    S_ERASE   = 6'b001000,
    S_COMPACT = 6'b010000,
    S_FINISH  = 6'b100000
  } state_e;

  state_e             state_d, state_q;
  logic [AW-1:0]      p_d, p_q, run_d, run_q, start_d, start_q;
  logic               found_d, found_q, hit_d, hit_q;
  logic [7:0]         len_d, len_q;
  logic [HandleW-1:0] h_d, h_q;
  logic [1:0]         rst_d, rst_q;
  logic [16:0]        nh_d, nh_q;
  logic               ov_d, ov_q;
  logic [1:0]         os_d, os_q;
  logic [HandleW-1:0] oh_d, oh_q;
  logic [HandleW-1:0] gh_d, gh_q;
  logic               last, free;
  logic [AW-1:0]      run_n;

  assign in_ready_o = (state_q == S_IDLE);
  assign last       = (p_q == m_i - AW'(1));
  assign free       = (head_i == '0);
  assign run_n      = free ? run_q + AW'(1) : '0;

  always_comb begin
    state_d = state_q;
    p_d = p_q; run_d = run_q; start_d = start_q;
    found_d = found_q; hit_d = hit_q;
    len_d = len_q; h_d = h_q; rst_d = rst_q; nh_d = nh_q;
    ov_d = ov_q; os_d = os_q; oh_d = oh_q; gh_d = gh_q;
    ctrl_o = '{mode: CM_HOLD, phase: p_q[0], tail: head_i};
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      // Take a new request and decide which pass it needs.
      S_IDLE: begin
        if (in_valid_i) begin
          len_d = request_length_i;
          h_d = erase_handle_i;
          p_d = '0; run_d = '0; found_d = 1'b0; hit_d = 1'b0;
          case (kind_i)
            KIND_ALLOC: begin
              if (request_length_i != '0 && int'(request_length_i) <= int'(m_i)
                  && nh_q <= HandleLimit) begin
                state_d = S_SCAN;
              end else begin
                rst_d = ST_NULL; state_d = S_FINISH;
              end
            end
            KIND_ERASE: begin
              if (erase_handle_i != '0 && m_i != '0) begin
                state_d = S_ERASE;
              end else begin
                rst_d = ST_ILLEGAL; state_d = S_FINISH;
              end
            end
            KIND_DEFRAG: begin
              if (int'(m_i) > 1) state_d = S_COMPACT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      // Rotate the row once, looking for the first free run.
      S_SCAN: begin
        ctrl_o.mode = CM_SHIFT;
        run_d = run_n;
        if (free && !found_q && int'(run_n) == int'(len_q)) begin
          found_d = 1'b1;
          start_d = AW'(int'(p_q) + 1 - int'(len_q));
        end
        p_d = p_q + AW'(1);
        if (last) begin
          p_d = '0;
          if (found_d) begin
            state_d = S_FILL;
          end else begin
            rst_d = ST_NULL; state_d = S_FINISH;
          end
        end
      end
      // Rotate again, writing the new handle over the chosen run.
      S_FILL: begin
        ctrl_o.mode = CM_SHIFT;
        if (p_q >= start_q && int'(p_q) < int'(start_q) + int'(len_q)) begin
          ctrl_o.tail = nh_q[HandleW-1:0];
        end
        p_d = p_q + AW'(1);
        if (last) begin
          rst_d = ST_ALLOCATED;
          gh_d = nh_q[HandleW-1:0];
          nh_d = nh_q + 17'd1;
          state_d = S_FINISH;
        end
      end
      // Rotate once, clearing every cell of the handle.
      S_ERASE: begin
        ctrl_o.mode = CM_SHIFT;
        if (head_i == h_q) begin
          ctrl_o.tail = '0;
          hit_d = 1'b1;
        end
        p_d = p_q + AW'(1);
        if (last) begin
          if (hit_d) begin
            state_d = S_IDLE;
          end else begin
            rst_d = ST_ILLEGAL; state_d = S_FINISH;
          end
        end
      end
      // Odd-even transposition rounds move every free cell to the top.
      S_COMPACT: begin
        ctrl_o.mode = CM_COMPACT;
        p_d = p_q + AW'(1);
        if (last) state_d = S_IDLE;
      end
      // Hand the result to the output register once it is free.
      S_FINISH: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1; os_d = rst_q; oh_d = (rst_q == ST_ALLOCATED) ? gh_q : '0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      nh_q    <= 17'd1;
      ov_q    <= 1'b0;
      p_q     <= '0;
    end else begin
      state_q <= state_d;
      nh_q    <= nh_d;
      ov_q    <= ov_d;
      p_q     <= p_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q <= run_d; start_q <= start_d; found_q <= found_d; hit_q <= hit_d;
    len_q <= len_d; h_q <= h_d; rst_q <= rst_d; os_q <= os_d; oh_q <= oh_d;
    gh_q <= gh_d;
  end

  assign out_valid_o = ov_q;
  assign status_o    = os_q;
  assign handle_o    = oh_q;

endmodule
`default_nettype wire

// ----- design/ffca_checker.sv -----
// Port-level checks of the first-fit cell allocator, bound to the top level.
`default_nettype none
module ffca_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_o,
  input wire [1:0]  kind_i,
  input wire        out_valid_o,
  input wire        out_ready_i,
  input wire [1:0]  status_o,
  input wire [15:0] handle_o
);
  import ffca_pkg::*;

  // An accepted alloc always keeps the block busy for the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i == KIND_ALLOC |=> !in_ready_o)
    else $error("alloc accepted but block idle next cycle");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(handle_o))
    else $error("stalled result changed");

  // Only a granted alloc carries a handle, and it is never zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_ALLOCATED) == (handle_o != '0))
    else $error("handle does not match status");

  // Status codes stay within the defined set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_ALLOCATED || status_o == ST_NULL
                    || status_o == ST_ILLEGAL)
    else $error("undefined status code");

endmodule

bind first_fit_cell_allocator ffca_checker u_ffca_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .kind_i,
  .out_valid_o, .out_ready_i, .status_o, .handle_o
);
`default_nettype wire
